FILE: sv/bdw_pkg.sv
// Shared types and constants for the depth-weighted bid/ask block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bdw_pkg;

  localparam int PRICE_W  = 31;
  localparam int SIZE_W   = 24;
  localparam int PCT_W    = 7;
  localparam int CNT_W    = 7;
  localparam int TOT_W    = 31;
  localparam int TGT_W    = 32;
  localparam int PROD_W   = PRICE_W + SIZE_W;
  localparam int ACC_W    = 61;
  localparam int FRAC_W   = 16;
  localparam int DIV_W    = ACC_W + FRAC_W;
  localparam int DIVC_W   = 7;
  localparam int AVG_W    = 47;
  localparam int TARGET_W = 29;

  // floor(x / 100) as floor(x * ceil(2^44 / 100) / 2^44), exact for x below 2^44 / 84;
  // the multiplier is split in a 20-bit high and an 18-bit low part
  localparam int X_W       = TOT_W + PCT_W;
  localparam int RCP_HI_W  = 20;
  localparam int RCP_LO_W  = 18;
  localparam int PHI_W     = X_W + RCP_HI_W;
  localparam int PLO_W     = X_W + RCP_LO_W;
  localparam int RSUM_W    = PHI_W + 1;
  localparam int RCP_SHIFT = 26;

  localparam logic [RCP_HI_W-1:0] RCP_HI = 20'd671088;
  localparam logic [RCP_LO_W-1:0] RCP_LO = 18'd167773;

  localparam logic [PCT_W-1:0] PCT_RESET = 7'd95;

  typedef struct packed {
    logic [PRICE_W-1:0] bid_price;
    logic [SIZE_W-1:0]  bid_size;
    logic [PRICE_W-1:0] ask_price;
    logic [SIZE_W-1:0]  ask_size;
    logic               last_level;
  } in_item_t;

  typedef struct packed {
    logic                valid_res;
    logic [TARGET_W-1:0] target_size;
    logic [AVG_W-1:0]    bid_average;
    logic [AVG_W-1:0]    ask_average;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [TOT_W-1:0] bid_total;
    logic [TOT_W-1:0] ask_total;
    logic [PCT_W-1:0] pct;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_TB_MUL,
    BK_TB_RCP,
    BK_TA_MUL,
    BK_TA_RCP,
    BK_TARGET,
    BK_WALK_RD,
    BK_WALK_MUL,
    BK_WALK_ACC,
    BK_AVG_GO,
    BK_AVG_WAIT,
    BK_CHECK,
    BK_FINISH
  } back_state_t;

endpackage
`default_nettype wire

FILE: sv/bdw_queue.sv
// Two-entry job queue between the loader and the evaluator.
// Depends on bdw_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none
module bdw_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire bdw_pkg::job_t push_job,
  output logic              ready,
  input  wire logic         pop,
  output logic              valid,
  output bdw_pkg::job_t     head
);

  bdw_pkg::job_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign ready = (fill != 2'd2);
  assign valid = (fill != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && ready) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && valid) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push && ready} - {1'b0, pop && valid};
    end
  end

endmodule
`default_nettype wire

FILE: sv/bdw_front.sv
// Loader: takes levels, stores them, keeps side totals, posts a job per book.
// Depends on bdw_pkg; holds the level memory read by the evaluator.
`timescale 1ns / 1ps
`default_nettype none
module bdw_front #(
  parameter int BOOK_LEVELS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bdw_pkg::in_item_t  in_data,
  input  wire logic [bdw_pkg::PCT_W-1:0] pct,
  output logic                    push,
  output bdw_pkg::job_t           push_job,
  input  wire logic               q_ready,
  input  wire logic               book_done,
  input  wire logic [$clog2(BOOK_LEVELS)-1:0] rd_addr,
  output bdw_pkg::in_item_t       rd_data
);

  localparam int IDX_W = $clog2(BOOK_LEVELS);
  localparam int LC_W  = $clog2(BOOK_LEVELS + 1);
  localparam logic [LC_W-1:0] LEVELS = LC_W'(BOOK_LEVELS);

  bdw_pkg::in_item_t levels [BOOK_LEVELS];

  logic [LC_W-1:0]            count;
  logic [LC_W-1:0]            count_next;
  logic [bdw_pkg::TOT_W-1:0]  bid_total;
  logic [bdw_pkg::TOT_W-1:0]  bid_total_next;
  logic [bdw_pkg::TOT_W-1:0]  ask_total;
  logic [bdw_pkg::TOT_W-1:0]  ask_total_next;
  logic                       busy;
  logic                       accept;
  logic                       room;

  assign in_stall = busy || !q_ready;
  assign accept   = in_valid && !in_stall;
  assign room     = (count < LEVELS);
  assign push     = accept && in_data.last_level;

  always_comb begin
    count_next     = count;
    bid_total_next = bid_total;
    ask_total_next = ask_total;
    if (room) begin
      count_next     = count + 1'b1;
      bid_total_next = bid_total + bdw_pkg::TOT_W'(in_data.bid_size);
      ask_total_next = ask_total + bdw_pkg::TOT_W'(in_data.ask_size);
    end
  end

  always_comb begin
    push_job.n         = bdw_pkg::CNT_W'(count_next);
    push_job.bid_total = bid_total_next;
    push_job.ask_total = ask_total_next;
    push_job.pct       = pct;
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      levels[count[IDX_W-1:0]] <= in_data;
    end
    rd_data <= levels[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      bid_total <= '0;
      ask_total <= '0;
      busy      <= 1'b0;
    end else begin
      if (push) begin
        count     <= '0;
        bid_total <= '0;
        ask_total <= '0;
        busy      <= 1'b1;
      end else if (accept) begin
        count     <= count_next;
        bid_total <= bid_total_next;
        ask_total <= ask_total_next;
      end
      if (book_done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/bdw_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bdw_pkg for widths; used for the average divisions.
`timescale 1ns / 1ps
`default_nettype none
module bdw_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bdw_pkg::DIV_W-1:0]   dividend,
  input  wire logic [bdw_pkg::TOT_W-1:0]   divisor,
  output logic                             done,
  output logic [bdw_pkg::DIV_W-1:0]        quotient
);

  localparam logic [bdw_pkg::DIVC_W-1:0] STEPS = bdw_pkg::DIVC_W'(bdw_pkg::DIV_W);

  logic [bdw_pkg::TOT_W-1:0]  den;
  logic [bdw_pkg::TOT_W-1:0]  rem;
  logic [bdw_pkg::TOT_W:0]    shifted;
  logic [bdw_pkg::TOT_W:0]    diff;
  logic [bdw_pkg::DIVC_W-1:0] steps_left;
  logic                       busy;
  logic                       fits;

  assign shifted = {rem, quotient[bdw_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign fits    = (shifted >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[bdw_pkg::DIV_W-2:0], fits};
      rem      <= fits ? diff[bdw_pkg::TOT_W-1:0] : shifted[bdw_pkg::TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        steps_left <= STEPS;
      end else if (busy) begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == bdw_pkg::DIVC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/bdw_back.sv
// Evaluator: forms the target, walks both sides, divides, registers the result.
// Depends on bdw_pkg and bdw_div; reads levels through the loader's memory port.
`timescale 1ns / 1ps
`default_nettype none
module bdw_back #(
  parameter int BOOK_LEVELS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire bdw_pkg::job_t      q_head,
  output logic                    pop,
  output logic [$clog2(BOOK_LEVELS)-1:0] rd_addr,
  input  wire bdw_pkg::in_item_t  rd_data,
  output logic                    book_done,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bdw_pkg::out_item_t      out_data
);

  localparam int IDX_W = $clog2(BOOK_LEVELS);

  bdw_pkg::back_state_t state;
  bdw_pkg::back_state_t state_next;

  bdw_pkg::job_t               job;
  logic                        ok;
  logic                        side;
  logic [bdw_pkg::X_W-1:0]     xprod;
  logic [bdw_pkg::PHI_W-1:0]   p_hi;
  logic [bdw_pkg::PLO_W-1:0]   p_lo;
  logic [bdw_pkg::RSUM_W-1:0]  rcp_sum;
  logic [bdw_pkg::TGT_W-1:0]   rcp_quo;
  logic [bdw_pkg::TGT_W-1:0]   tb;
  logic [bdw_pkg::TGT_W-1:0]   target;
  logic [bdw_pkg::TGT_W-1:0]   ta;
  logic [bdw_pkg::CNT_W-1:0]   idx;
  logic [bdw_pkg::CNT_W-1:0]   idx_inc;
  logic [bdw_pkg::TOT_W-1:0]   seen;
  logic [bdw_pkg::ACC_W-1:0]   acc;
  logic [bdw_pkg::PROD_W-1:0]  prod;
  logic [bdw_pkg::SIZE_W-1:0]  lvl_size;
  logic [bdw_pkg::AVG_W-1:0]   bid_avg;
  logic [bdw_pkg::AVG_W-1:0]   ask_avg;
  logic                        out_free;
  logic                        reached;

  logic                        div_start;
  logic [bdw_pkg::DIV_W-1:0]   div_dividend;
  logic [bdw_pkg::TOT_W-1:0]   div_divisor;
  logic                        div_done;
  logic [bdw_pkg::DIV_W-1:0]   div_quotient;

  bdw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign out_free = !out_valid || !out_stall;
  assign reached  = ({1'b0, seen} >= target);
  assign idx_inc  = idx + 1'b1;
  assign rcp_sum  = {1'b0, p_hi}
                  + bdw_pkg::RSUM_W'(p_lo[bdw_pkg::PLO_W-1:bdw_pkg::RCP_LO_W]);
  assign rcp_quo  = rcp_sum[bdw_pkg::RCP_SHIFT +: bdw_pkg::TGT_W];
  assign ta       = (rcp_quo == '0) ? bdw_pkg::TGT_W'(1) : rcp_quo;
  assign rd_addr  = idx[IDX_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      bdw_pkg::BK_IDLE:     if (q_valid) state_next = bdw_pkg::BK_TB_MUL;
      bdw_pkg::BK_TB_MUL:   state_next = bdw_pkg::BK_TB_RCP;
      bdw_pkg::BK_TB_RCP:   state_next = bdw_pkg::BK_TA_MUL;
      bdw_pkg::BK_TA_MUL:   state_next = bdw_pkg::BK_TA_RCP;
      bdw_pkg::BK_TA_RCP:   state_next = bdw_pkg::BK_TARGET;
      bdw_pkg::BK_TARGET: begin
        state_next = ok ? bdw_pkg::BK_WALK_RD : bdw_pkg::BK_FINISH;
      end
      bdw_pkg::BK_WALK_RD: begin
        if (reached) begin
          state_next = bdw_pkg::BK_AVG_GO;
        end else if (idx >= job.n) begin
          state_next = bdw_pkg::BK_FINISH;
        end else begin
          state_next = bdw_pkg::BK_WALK_MUL;
        end
      end
      bdw_pkg::BK_WALK_MUL: state_next = bdw_pkg::BK_WALK_ACC;
      bdw_pkg::BK_WALK_ACC: begin
        state_next = (idx_inc == job.n) ? bdw_pkg::BK_FINISH : bdw_pkg::BK_WALK_RD;
      end
      bdw_pkg::BK_AVG_GO:   state_next = bdw_pkg::BK_AVG_WAIT;
      bdw_pkg::BK_AVG_WAIT: begin
        if (div_done) begin
          state_next = side ? bdw_pkg::BK_CHECK : bdw_pkg::BK_WALK_RD;
        end
      end
      bdw_pkg::BK_CHECK:    state_next = bdw_pkg::BK_FINISH;
      bdw_pkg::BK_FINISH:   if (out_free) state_next = bdw_pkg::BK_IDLE;
      default:              state_next = bdw_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = seen;
    book_done    = 1'b0;
    unique case (state)
      bdw_pkg::BK_IDLE:   pop = q_valid;
      bdw_pkg::BK_AVG_GO: begin
        div_start    = 1'b1;
        div_dividend = {acc, {bdw_pkg::FRAC_W{1'b0}}};
      end
      bdw_pkg::BK_FINISH: book_done = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdw_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bdw_pkg::BK_IDLE: begin
        job  <= q_head;
        ok   <= (q_head.bid_total != '0) && (q_head.ask_total != '0);
        side <= 1'b0;
        idx  <= '0;
        seen <= '0;
        acc  <= '0;
      end
      bdw_pkg::BK_TB_MUL: begin
        xprod <= bdw_pkg::X_W'(job.bid_total) * bdw_pkg::X_W'(job.pct);
      end
      bdw_pkg::BK_TB_RCP: begin
        p_hi <= bdw_pkg::PHI_W'(xprod) * bdw_pkg::PHI_W'(bdw_pkg::RCP_HI);
        p_lo <= bdw_pkg::PLO_W'(xprod) * bdw_pkg::PLO_W'(bdw_pkg::RCP_LO);
      end
      bdw_pkg::BK_TA_MUL: begin
        tb    <= ta;
        xprod <= bdw_pkg::X_W'(job.ask_total) * bdw_pkg::X_W'(job.pct);
      end
      bdw_pkg::BK_TA_RCP: begin
        p_hi <= bdw_pkg::PHI_W'(xprod) * bdw_pkg::PHI_W'(bdw_pkg::RCP_HI);
        p_lo <= bdw_pkg::PLO_W'(xprod) * bdw_pkg::PLO_W'(bdw_pkg::RCP_LO);
      end
      bdw_pkg::BK_TARGET: target <= (ta > tb) ? ta : tb;
      bdw_pkg::BK_WALK_RD: if (!reached && idx >= job.n) ok <= 1'b0;
      bdw_pkg::BK_WALK_MUL: begin
        prod     <= side ? rd_data.ask_price * rd_data.ask_size
                         : rd_data.bid_price * rd_data.bid_size;
        lvl_size <= side ? rd_data.ask_size : rd_data.bid_size;
      end
      bdw_pkg::BK_WALK_ACC: begin
        seen <= seen + bdw_pkg::TOT_W'(lvl_size);
        acc  <= acc + bdw_pkg::ACC_W'(prod);
        idx  <= idx_inc;
        if (idx_inc == job.n) ok <= 1'b0;
      end
      bdw_pkg::BK_AVG_WAIT: begin
        if (div_done) begin
          if (side) begin
            ask_avg <= div_quotient[bdw_pkg::AVG_W-1:0];
          end else begin
            bid_avg <= div_quotient[bdw_pkg::AVG_W-1:0];
          end
          side <= 1'b1;
          idx  <= '0;
          seen <= '0;
          acc  <= '0;
        end
      end
      bdw_pkg::BK_CHECK: begin
        if (ask_avg < bid_avg || ask_avg == '0 || bid_avg == '0) ok <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (book_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (book_done) begin
      out_data.valid_res   <= ok;
      out_data.target_size <= ok ? target[bdw_pkg::TARGET_W-1:0] : '0;
      out_data.bid_average <= ok ? bid_avg : '0;
      out_data.ask_average <= ok ? ask_avg : '0;
    end
  end

endmodule
`default_nettype wire

FILE: sv/book_depth_weighted_bid_ask.sv
// Top level of the depth-weighted bid/ask average block.
// Depends on bdw_pkg, bdw_front, bdw_queue, bdw_back.
//
//   port group   dir  handshake            payload
//   in_*         in   in_valid / in_stall  bdw_pkg::in_item_t
//   out_*        out  out_valid / out_stall bdw_pkg::out_item_t
//   cfg_*        in   cfg_we               depth_percent, 7 bits
//
// A level transfers when in_valid is high and in_stall is low. After the closing level the
// input stalls until the book is evaluated: reciprocal multiplies for the side targets, then
// per side a read, multiply and accumulate step per level of the walk and one 77-step
// division on the shared divider. Reset is synchronous; depth_percent resets to 95. The
// result waits in an output register while out_stall is high.
`timescale 1ns / 1ps
`default_nettype none
module book_depth_weighted_bid_ask #(
  parameter int BOOK_LEVELS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire bdw_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output bdw_pkg::out_item_t              out_data,
  input  wire logic                       cfg_we,
  input  wire logic [bdw_pkg::PCT_W-1:0]  cfg_wdata
);

  logic [bdw_pkg::PCT_W-1:0]     depth_percent;
  logic                          push;
  bdw_pkg::job_t                 push_job;
  logic                          q_ready;
  logic                          q_valid;
  bdw_pkg::job_t                 q_head;
  logic                          pop;
  logic                          book_done;
  logic [$clog2(BOOK_LEVELS)-1:0] rd_addr;
  bdw_pkg::in_item_t             rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_percent <= bdw_pkg::PCT_RESET;
    end else if (cfg_we) begin
      depth_percent <= cfg_wdata;
    end
  end

  bdw_front #(.BOOK_LEVELS(BOOK_LEVELS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .pct       (depth_percent),
    .push      (push),
    .push_job  (push_job),
    .q_ready   (q_ready),
    .book_done (book_done),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  bdw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .ready    (q_ready),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  bdw_back #(.BOOK_LEVELS(BOOK_LEVELS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .book_done (book_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
